// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the port-level checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AST_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define AST_IMPL(lbl, clk, rstn, ante, cons, msg) \
    `AST_PROP(lbl, clk, rstn, (ante) |-> (cons), msg)

// Next-cycle implication.
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
    `AST_PROP(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

// ===== rtl/ifa_pkg.sv =====
// ---------------------------------------------------------------------------
// ifa_pkg
// Types, codes, power tables and the glyph map of the ASCII formatter.
// ---------------------------------------------------------------------------
package ifa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int OP_W            = 2;
    localparam int CHAR_W          = 8;
    localparam int POW_W           = 32;
    localparam int DIGIT_W         = 4;
    localparam int DEC_DIGITS      = 10;
    localparam int HEX_DIGITS      = 8;
    localparam int POS_W           = $clog2(DEC_DIGITS);

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [POW_W-1:0]  t_pow;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [DIGIT_W-1:0] t_digit;

    localparam t_op OP_UDEC = 2'd0;
    localparam t_op OP_HEX  = 2'd1;
    localparam t_op OP_SDEC = 2'd2;

    localparam t_char CHR_ZERO    = 8'h30;
    localparam t_char CHR_UPPER_A = 8'h41;
    localparam t_char CHR_MINUS   = 8'h2D;
    localparam t_char CHR_NINE    = 8'h39;
    localparam t_char CHR_UPPER_F = 8'h46;

    // Power of the radix for a digit position, most significant position first.
    function automatic t_pow f_pow(input logic hex, input t_pos pos);
        t_pow p;
        p = 32'd1;
        if (hex) begin
            case (pos)
                4'd0:    p = 32'h1000_0000;
                4'd1:    p = 32'h0100_0000;
                4'd2:    p = 32'h0010_0000;
                4'd3:    p = 32'h0001_0000;
                4'd4:    p = 32'h0000_1000;
                4'd5:    p = 32'h0000_0100;
                4'd6:    p = 32'h0000_0010;
                default: p = 32'h0000_0001;
            endcase
        end else begin
            case (pos)
                4'd0:    p = 32'd1000000000;
                4'd1:    p = 32'd100000000;
                4'd2:    p = 32'd10000000;
                4'd3:    p = 32'd1000000;
                4'd4:    p = 32'd100000;
                4'd5:    p = 32'd10000;
                4'd6:    p = 32'd1000;
                4'd7:    p = 32'd100;
                4'd8:    p = 32'd10;
                default: p = 32'd1;
            endcase
        end
        return p;
    endfunction

    function automatic t_char f_glyph(input t_digit d);
        t_char c;
        if (d < 4'd10) begin
            c = CHR_ZERO + CHAR_W'(d);
        end else begin
            c = CHR_UPPER_A + CHAR_W'(d) - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter.sv =====
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter
// Prints one value as unsigned decimal, uppercase hex or signed decimal,
// one ASCII character per output word, with leading zeros suppressed.
// ---------------------------------------------------------------------------
// Sequence: the value is accepted, a minus sign is printed when needed, and then
// every digit position (ten decimal, eight hex) is reduced by repeated subtraction
// of its radix power and then printed or skipped; output stalls hold the printing.
// A single compare-and-subtract unit does this, removing one radix power a cycle.
// One value at a time; an unused mode code is taken and prints nothing.
// Reset (synchronous, active low) clears the sequencer and the output valid flag.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = ifa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ifa_pkg::t_op                 i_op,
    input  logic [ifa_pkg::FIELD_W-1:0]  i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ifa_pkg::t_char               o_out_char,
    output logic                         o_last
);
    import ifa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SIGN  = 2'd1;
    localparam logic [1:0] S_DIGIT = 2'd2;

    localparam t_pos DEC_LAST = t_pos'(DEC_DIGITS - 1);
    localparam t_pos HEX_LAST = t_pos'(HEX_DIGITS - 1);

    logic [1:0]             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic                   r_hex, n_hex;
    t_pos                   r_pos, n_pos;
    t_digit                 r_digit, n_digit;
    logic                   r_started, n_started;
    logic                   r_out_valid, n_out_valid;
    t_char                  r_out_char, n_out_char;
    logic                   r_last, n_last;

    logic [VALUE_WIDTH-1:0] w_value;
    t_pow                   w_pow;
    t_pow                   w_mag_ext;
    logic                   w_ge;
    logic                   w_last_pos;
    logic                   w_show;
    logic                   w_out_free;

    assign w_value    = i_value[VALUE_WIDTH-1:0];
    assign w_pow      = f_pow(r_hex, r_pos);
    assign w_mag_ext  = POW_W'(r_mag);
    assign w_ge       = (w_mag_ext >= w_pow);
    assign w_last_pos = (r_pos == (r_hex ? HEX_LAST : DEC_LAST));
    // The last position always prints, which also covers a zero value.
    assign w_show     = (r_digit != '0) || r_started || w_last_pos;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_hex       = r_hex;
        n_pos       = r_pos;
        n_digit     = r_digit;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char  = r_out_char;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_hex     = (i_op == OP_HEX);
                    n_pos     = '0;
                    n_digit   = '0;
                    n_started = 1'b0;
                    n_mag     = w_value;
                    case (i_op)
                        OP_UDEC, OP_HEX: begin
                            n_state = S_DIGIT;
                        end
                        OP_SDEC: begin
                            if (w_value[VALUE_WIDTH-1]) begin
                                n_mag   = ~w_value + VALUE_WIDTH'(1);
                                n_state = S_SIGN;
                            end else begin
                                n_state = S_DIGIT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHR_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_ge) begin
                    n_mag   = VALUE_WIDTH'(w_mag_ext - w_pow);
                    n_digit = r_digit + t_digit'(1);
                end else if (!w_show) begin
                    n_pos   = r_pos + t_pos'(1);
                    n_digit = '0;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = f_glyph(r_digit);
                    n_last      = w_last_pos;
                    n_started   = 1'b1;
                    n_digit     = '0;
                    n_pos       = r_pos + t_pos'(1);
                    if (w_last_pos) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_hex      <= n_hex;
        r_pos      <= n_pos;
        r_digit    <= n_digit;
        r_started  <= n_started;
        r_out_char <= n_out_char;
        r_last     <= n_last;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_last;

endmodule

// ===== rtl/ifa_checker.sv =====
// ---------------------------------------------------------------------------
// ifa_checker
// Port-level assertions for the ASCII formatter, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ifa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input ifa_pkg::t_op                 i_op,
    input logic [ifa_pkg::FIELD_W-1:0]  i_value,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input ifa_pkg::t_char               o_out_char,
    input logic                         o_last
);
    import ifa_pkg::*;

    // A stalled word keeps its character and flag.
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_char) && $stable(o_last), "output word changed while stalled")

    // Only digits, hex letters and the minus sign are ever printed.
    `AST_IMPL(a_char_set, i_clk, i_rst_n, o_out_valid, (o_out_char >= CHR_ZERO && o_out_char <= CHR_NINE) || (o_out_char >= CHR_UPPER_A && o_out_char <= CHR_UPPER_F) || o_out_char == CHR_MINUS, "illegal character")

    // A minus sign is always followed by digits.
    `AST_IMPL(a_minus_not_last, i_clk, i_rst_n, o_out_valid && o_out_char == CHR_MINUS, !o_last, "minus sign flagged as last")

    // Once the block is free again, a waiting word can only be a final one.
    `AST_IMPL(a_idle_last, i_clk, i_rst_n, o_out_valid && o_in_ready, o_last, "pending word not last while ready")

    // An accepted value in a valid mode leaves the block busy in the cycle after it is taken.
    `AST_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_op == OP_UDEC || i_op == OP_HEX || i_op == OP_SDEC), !o_in_ready, "ready after accepting a value")

endmodule

bind integer_to_ascii_formatter ifa_checker u_ifa_checker (.*);

// ===== tb/ascii_format_checker.sv =====
// ---------------------------------------------------------------------------
// ascii_format_checker
// Watches both channels of the ASCII formatter. Every accepted value is
// turned into the characters it should print, and every accepted output
// word is compared with the oldest of them.
// ---------------------------------------------------------------------------
module ascii_format_checker #(
    parameter int VALUE_WIDTH = ifa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  ifa_pkg::t_op                 i_op,
    input  logic [ifa_pkg::FIELD_W-1:0]  i_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  ifa_pkg::t_char               i_out_char,
    input  logic                         i_last,
    output int                           o_error_count,
    output int                           o_pending
);

    import ifa_pkg::*;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_char_word;

    localparam logic [FIELD_W-1:0] VALUE_MASK = {FIELD_W{1'b1}} >> (FIELD_W - VALUE_WIDTH);

    t_char_word expected_chars[$];
    int         mismatches = 0;
    int         waiting    = 0;

    assign o_error_count = mismatches;
    assign o_pending     = waiting;

    // Queues the characters that one value prints. An unused mode prints nothing.
    function automatic void format_value(input t_op mode, input logic [FIELD_W-1:0] raw);
        logic [FIELD_W-1:0] mag;
        logic [FIELD_W-1:0] radix;
        logic [FIELD_W-1:0] digit;
        t_char              digits[$];
        t_char_word         w;
        if (mode != OP_UDEC && mode != OP_HEX && mode != OP_SDEC) begin
            return;
        end
        mag   = raw & VALUE_MASK;
        radix = (mode == OP_HEX) ? 16 : 10;
        if (mode == OP_SDEC && mag[VALUE_WIDTH-1]) begin
            w.ch   = CHR_MINUS;
            w.last = 1'b0;
            expected_chars.push_back(w);
            // The most negative value negates to itself, which is the right magnitude.
            mag = (~mag + 1'b1) & VALUE_MASK;
        end
        do begin
            digit = mag % radix;
            digits.push_front((digit < 10) ? CHR_ZERO + t_char'(digit)
                                           : CHR_UPPER_A + t_char'(digit - 10));
            mag = mag / radix;
        end while (mag != 0);
        foreach (digits[i]) begin
            w.ch   = digits[i];
            w.last = (i == digits.size() - 1);
            expected_chars.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_char_word want;
        if (i_rst_n) begin
            // Compare before queueing, so a word cannot match a value taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("out_char: expected no word, actual 0x%h (last %b)",
                           i_out_char, i_last);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_char !== want.ch) begin
                        $error("out_char: expected 0x%h, actual 0x%h", want.ch, i_out_char);
                        mismatches = mismatches + 1;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, i_last);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                format_value(i_op, i_value);
            end
        end
        waiting = expected_chars.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Feeds the ASCII formatter a directed set of edge values and then random
// values in all modes, under three patterns of sender and receiver stalls,
// and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module testbench;

    import ifa_pkg::*;

    localparam t_op OP_UNUSED      = 2'd3;
    localparam int  PHASE_VALUES   = 82;
    localparam int  DRAIN_CYCLES   = 150;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    t_op                 op          = OP_UDEC;
    logic [FIELD_W-1:0]  value       = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    t_char               out_char;
    logic                last;
    int                  error_count;
    int                  pending;
    int                  sender_idle_pct   = 24;
    int                  receiver_idle_pct = 74;

    integer_to_ascii_formatter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_op        (op),
        .i_value     (value),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_char  (out_char),
        .o_last      (last)
    );

    ascii_format_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_op          (op),
        .i_value       (value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_char    (out_char),
        .i_last        (last),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic offer_value(input t_op mode, input logic [FIELD_W-1:0] v);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        op       <= mode;
        value    <= v;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_op                mode;
        logic [FIELD_W-1:0] v;
        int                 taken;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero in every mode, the extremes, radix power boundaries and the unused mode.
        offer_value(OP_UDEC, 32'd0);
        offer_value(OP_HEX, 32'd0);
        offer_value(OP_SDEC, 32'd0);
        offer_value(OP_UDEC, 32'hFFFF_FFFF);
        offer_value(OP_HEX, 32'hFFFF_FFFF);
        offer_value(OP_SDEC, 32'h8000_0000);
        offer_value(OP_SDEC, 32'h7FFF_FFFF);
        offer_value(OP_SDEC, 32'hFFFF_FFFF);
        offer_value(OP_UNUSED, 32'h1234_5678);
        offer_value(OP_UDEC, 32'd1000000000);
        offer_value(OP_UDEC, 32'd999999999);
        offer_value(OP_HEX, 32'h1000_0000);
        offer_value(OP_HEX, 32'h0FFF_FFFF);
        offer_value(OP_HEX, 32'hABCD_EF01);
        offer_value(OP_UDEC, 32'd9);
        offer_value(OP_UDEC, 32'd10);
        offer_value(OP_SDEC, -32'sd10);
        offer_value(OP_SDEC, 32'd1);
        offer_value(OP_HEX, 32'h0000_000A);
        offer_value(OP_UDEC, 32'h8000_0000);
        offer_value(OP_UNUSED, 32'd0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 24;
                    receiver_idle_pct = 74;
                end
                1: begin
                    sender_idle_pct   = 74;
                    receiver_idle_pct = 24;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            taken = 0;
            while (taken < PHASE_VALUES) begin
                mode = ($urandom_range(19) == 0) ? OP_UNUSED : t_op'($urandom_range(2));
                // Mix full-width values with short ones so every digit count shows up.
                case ($urandom_range(3))
                    0:       v = $urandom;
                    1:       v = $urandom >> $urandom_range(31);
                    2:       v = $urandom_range(20);
                    default: v = -($urandom_range(1000));
                endcase
                offer_value(mode, v);
                if (mode != OP_UNUSED) begin
                    taken++;
                end
            end
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
